FILE: src/timer_prescaler_ctc_postscaler_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer unit
// Concurrent assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TIMER_PRESCALER_CTC_POSTSCALER_UNIT_MACROS_SVH
`define TIMER_PRESCALER_CTC_POSTSCALER_UNIT_MACROS_SVH

// Same-cycle implication.
`define TPCPU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer unit assertion failed");

// Next-cycle implication.
`define TPCPU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer unit assertion failed");

`endif

FILE: src/tpcpu_pkg.sv
// ----------------------------------------------------------------------------
// Timer unit package
// Register indexes, mode codes, word layouts and the prescaler decode.
// ----------------------------------------------------------------------------
package tpcpu_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 32;
	localparam int PRESCALE_BITS  = 10;
	localparam int TARGET_BITS    = 32;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CLOCK_SELECT  = 3'd0,
		REG_CTC_MODE      = 3'd1,
		REG_COMPARE_VALUE = 3'd2,
		REG_OUTPUT_MODE   = 3'd3,
		REG_EVENT_TARGET  = 3'd4,
		REG_PRELOAD_VALUE = 3'd5
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CS_STOPPED = 3'd0,
		CS_DIV1    = 3'd1,
		CS_DIV8    = 3'd2,
		CS_DIV64   = 3'd3,
		CS_DIV256  = 3'd4,
		CS_DIV1024 = 3'd5
	} clock_sel_t;

	typedef enum logic [1:0] {
		PIN_NONE   = 2'd0,
		PIN_TOGGLE = 2'd1,
		PIN_CLEAR  = 2'd2,
		PIN_SET    = 2'd3
	} pin_action_t;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	// Input word, low bit first: tick, restart, zero padding.
	typedef struct packed {
		logic [5:0] pad;
		logic       restart;
		logic       tick;
	} in_word_t;

	// Result word, low bit first: count_value, overflow_pulse, match_pulse,
	// pin_level, period_event, zero padding.
	typedef struct packed {
		logic [3:0] pad;
		logic       period_event;
		logic       pin_level;
		logic       match_pulse;
		logic       overflow_pulse;
		logic [7:0] count_value;
	} out_word_t;

	typedef struct packed {
		logic                     enable;
		logic [PRESCALE_BITS-1:0] limit;
	} prescale_t;

	// The limit is the divisor minus one; unused selects stop the counter.
	function automatic prescale_t prescale_decode(input logic [2:0] sel);
		prescale_t p;
		p.enable = 1'b1;
		unique case (sel)
			CS_DIV1:    p.limit = 10'd0;
			CS_DIV8:    p.limit = 10'd7;
			CS_DIV64:   p.limit = 10'd63;
			CS_DIV256:  p.limit = 10'd255;
			CS_DIV1024: p.limit = 10'd1023;
			default: begin
				p.enable = 1'b0;
				p.limit  = '0;
			end
		endcase
		return p;
	endfunction

endpackage

FILE: src/timer_prescaler_ctc_postscaler_unit.sv
// ----------------------------------------------------------------------------
// Timer unit with prescaler, clear-on-compare mode and postscaler
// An 8-bit timer/counter advanced by one input word per source clock cycle.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Signals                          Word
//   s_axis    in         tvalid, tready, tdata[7:0]       tick, restart
//   m_axis    out        tvalid, tready, tdata[15:0]      count and pulses
//   cfg       in         valid, ready, index[2:0], data   register write
//
// A word is taken into the input register, is evaluated against the timer
// state and lands in the result register. One word is accepted per cycle
// while the result register is not stalled. Configuration writes are
// always accepted. The rate is set by the single state update per cycle
// on the counter path. A stalled result register holds its word; the
// input register then fills and tready falls until the result is taken.
// arst_n clears the state, the configuration registers and both valid flags.
//
module timer_prescaler_ctc_postscaler_unit #(
	parameter int EVENT_COUNT_BITS = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write channel.
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tpcpu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [tpcpu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	// Input stream.
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [7:0]                         s_axis_tdata,  // tick, restart, pad
	// Result stream.
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [15:0]                        m_axis_tdata   // count_value[7:0],
	                                                          // overflow_pulse,
	                                                          // match_pulse,
	                                                          // pin_level,
	                                                          // period_event, pad
);
	import tpcpu_pkg::*;

	// Configuration registers.
	logic [2:0]             clock_select_q;
	logic                   ctc_mode_q;
	logic [7:0]             compare_value_q;
	logic [1:0]             output_mode_q;
	logic [TARGET_BITS-1:0] event_target_q;
	logic [7:0]             preload_value_q;

	// Timer state.
	logic [PRESCALE_BITS-1:0]    prescale_q;
	logic [7:0]                  timer_q;
	logic [EVENT_COUNT_BITS-1:0] event_cnt_q;
	logic                        pin_q;

	// Input register and result register.
	logic      valid_s1;
	logic      tick_s1;
	logic      restart_s1;
	logic      valid_s2;
	out_word_t result_s2;

	logic      fire_s1;   // the word in the input register is evaluated now
	in_word_t  in_word;

	logic [PRESCALE_BITS-1:0]    prescale_d;
	logic [7:0]                  timer_d;
	logic [EVENT_COUNT_BITS-1:0] event_cnt_d;
	logic [EVENT_COUNT_BITS-1:0] event_inc;
	logic                        pin_d;
	logic                        ovf_d;
	logic                        match_d;
	logic                        evt_d;
	logic                        post_hit;
	logic                        advance;
	prescale_t                   presc;
	out_word_t                   result_d;

	assign cfg_ready     = 1'b1;
	assign in_word       = in_word_t'(s_axis_tdata);
	assign fire_s1       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = result_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_select_q  <= '0;
			ctc_mode_q      <= 1'b0;
			compare_value_q <= '0;
			output_mode_q   <= '0;
			event_target_q  <= '0;
			preload_value_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CLOCK_SELECT:  clock_select_q  <= cfg_data[2:0];
				REG_CTC_MODE:      ctc_mode_q      <= cfg_data[0];
				REG_COMPARE_VALUE: compare_value_q <= cfg_data[7:0];
				REG_OUTPUT_MODE:   output_mode_q   <= cfg_data[1:0];
				REG_EVENT_TARGET:  event_target_q  <= cfg_data[TARGET_BITS-1:0];
				REG_PRELOAD_VALUE: preload_value_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The postscaler count after one more overflow or match. It restarts
	// once it reaches the target; a zero target never fires.
	assign event_inc = event_cnt_q + EVENT_COUNT_BITS'(1);
	assign post_hit  = (event_target_q != '0) &&
	                   (TARGET_BITS'(event_inc) >= event_target_q);
	assign presc     = prescale_decode(clock_select_q);

	always_comb begin
		prescale_d  = prescale_q;
		timer_d     = timer_q;
		event_cnt_d = event_cnt_q;
		pin_d       = pin_q;
		ovf_d       = 1'b0;
		match_d     = 1'b0;
		evt_d       = 1'b0;
		advance     = 1'b0;
		if (restart_s1) begin
			// Restart wins over a tick in the same word; the pin is kept.
			prescale_d  = '0;
			event_cnt_d = '0;
			timer_d     = ctc_mode_q ? 8'd0 : preload_value_q;
		end else if (tick_s1 && presc.enable) begin
			// A count left above the limit by a select change fires at once.
			if (prescale_q >= presc.limit) begin
				prescale_d = '0;
				advance    = 1'b1;
			end else begin
				prescale_d = prescale_q + PRESCALE_BITS'(1);
			end
		end
		if (advance) begin
			if (timer_q == compare_value_q) begin
				match_d = 1'b1;
				unique case (output_mode_q)
					PIN_TOGGLE: pin_d = !pin_q;
					PIN_CLEAR:  pin_d = 1'b0;
					PIN_SET:    pin_d = 1'b1;
					PIN_NONE:   pin_d = pin_q;
				endcase
			end
			if (ctc_mode_q && match_d) begin
				timer_d     = 8'd0;
				event_cnt_d = post_hit ? '0 : event_inc;
				evt_d       = post_hit;
			end else if (timer_q == COUNT_MAX) begin
				// In clear-on-compare mode a wrap is not counted.
				timer_d = 8'd0;
				ovf_d   = 1'b1;
				if (!ctc_mode_q) begin
					event_cnt_d = post_hit ? '0 : event_inc;
					evt_d       = post_hit;
					if (post_hit) begin
						timer_d = preload_value_q;
					end
				end
			end else begin
				timer_d = timer_q + 8'd1;
			end
		end
		result_d                = '0;
		result_d.count_value    = timer_d;
		result_d.overflow_pulse = ovf_d;
		result_d.match_pulse    = match_d;
		result_d.pin_level      = pin_d;
		result_d.period_event   = evt_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prescale_q  <= '0;
			timer_q     <= '0;
			event_cnt_q <= '0;
			pin_q       <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				valid_s1 <= 1'b1;
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
			if (fire_s1) begin
				valid_s2    <= 1'b1;
				prescale_q  <= prescale_d;
				timer_q     <= timer_d;
				event_cnt_q <= event_cnt_d;
				pin_q       <= pin_d;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			tick_s1    <= in_word.tick;
			restart_s1 <= in_word.restart;
		end
		if (fire_s1) begin
			result_s2 <= result_d;
		end
	end

	`include "timer_prescaler_ctc_postscaler_unit_macros.svh"

	// An overflow leaves the counter at zero, or at the preload on an event.
	`TPCPU_ASSERT_IMP(a_ovf_count, fire_s1 && ovf_d,
		timer_d == 8'd0 || (evt_d && timer_d == preload_value_q))
	// In clear-on-compare mode only a match can raise the event.
	`TPCPU_ASSERT_IMP(a_ctc_event, fire_s1 && evt_d && ctc_mode_q, match_d)
	// A zero target never raises the event.
	`TPCPU_ASSERT_IMP(a_zero_target, fire_s1 && event_target_q == '0, !evt_d)
	// A word held in the input register by a stall is not lost.
	`TPCPU_ASSERT_NXT(a_s1_held, valid_s1 && !fire_s1, valid_s1)

endmodule
